@@ rtl/sasf_pkg.sv @@
// ----------------------------------------------------------------------------
// sasf_pkg - shared types and constants of the six-axis smoothing filter
// Field widths, default sizes, offset reset values and pipeline control.
// ----------------------------------------------------------------------------
package sasf_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int OFFSET_W          = 16;
  localparam int OUT_W             = 21;
  localparam int HISTORY_DEPTH_DEF = 5;
  localparam int AXIS_COUNT_DEF    = 6;

  // accel x, y, z, gyro x, y, z, spare, spare
  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET [8] = '{
    16'sd0, 16'sd0, 16'sd0, -16'sd59, 16'sd4, 16'sd4, 16'sd0, 16'sd0
  };

  // stage loads driven by the merge stage into every lane
  typedef struct packed {
    logic accept;   // input beat taken: update history and running sum
    logic load_a;   // capture offset-corrected magnitude
    logic load_b;   // capture reciprocal product
  } pipe_ctl_t;

endpackage

@@ rtl/sasf_lane.sv @@
// ----------------------------------------------------------------------------
// sasf_lane - one axis of the smoothing filter
// Holds the history line, a running sum and the axis offset; removes the
// offset and divides by the depth through a reciprocal multiply.
// ----------------------------------------------------------------------------
module sasf_lane
  import sasf_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int IDX_W         = 3,
  parameter int LANE          = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pipe_ctl_t                  ctl,
  input  logic                       cfg_we,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [OFFSET_W-1:0]        cfg_data,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic signed [OUT_W-1:0]    result
);

  localparam int LOG_D  = $clog2(HISTORY_DEPTH);
  localparam int HSUM_W = SAMPLE_W + LOG_D;
  localparam int DIFF_W = HSUM_W + 1;
  localparam int N      = DIFF_W + 4;
  localparam int S      = N + LOG_D;
  localparam int M_W    = N + 2;
  localparam int PROD_W = N + M_W;
  localparam int Q_W    = PROD_W - S;

  localparam logic signed [DIFF_W-1:0] D_S = DIFF_W'(HISTORY_DEPTH);
  localparam logic [M_W-1:0] RECIP =
    M_W'(((64'd1 << S) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));
  localparam logic signed [OFFSET_W-1:0] OFF_RST = OFFSET_RESET[LANE % 8];

  logic signed [SAMPLE_W-1:0] hist [HISTORY_DEPTH];
  logic signed [HSUM_W-1:0]   hsum;
  logic signed [HSUM_W-1:0]   hsum_next;
  logic signed [OFFSET_W-1:0] offset;

  logic signed [SAMPLE_W:0]   pair_sum;
  logic signed [SAMPLE_W:0]   pair_adj;
  logic signed [SAMPLE_W-1:0] smoothed;

  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          mag_next;
  logic [DIFF_W-1:0]          mag_a;
  logic                       neg_a;
  logic [PROD_W-1:0]          prod_b;
  logic                       neg_b;
  logic [Q_W-1:0]             quot;

  // halve toward zero: bias negative sums by one before the shift
  assign pair_sum  = {sample[SAMPLE_W-1], sample}
                   + {hist[HISTORY_DEPTH-1][SAMPLE_W-1], hist[HISTORY_DEPTH-1]};
  assign pair_adj  = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]};
  assign smoothed  = pair_adj[SAMPLE_W:1];
  assign hsum_next = hsum + HSUM_W'(smoothed) - HSUM_W'(hist[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= OFF_RST;
    end else if (cfg_we && (cfg_index == IDX_W'(LANE))) begin
      offset <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < HISTORY_DEPTH; d++) begin
        hist[d] <= '0;
      end
      hsum <= '0;
    end else if (ctl.accept) begin
      for (int d = 0; d < HISTORY_DEPTH - 1; d++) begin
        hist[d] <= hist[d+1];
      end
      hist[HISTORY_DEPTH-1] <= smoothed;
      hsum <= hsum_next;
    end
  end

  assign diff     = DIFF_W'(hsum) - DIFF_W'(offset) * D_S;
  assign mag_next = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      mag_a <= mag_next;
      neg_a <= diff[DIFF_W-1];
    end
  end

  // times 16 is the four zero bits; the reciprocal is exact for this range
  always_ff @(posedge clk) begin
    if (ctl.load_b) begin
      prod_b <= PROD_W'({mag_a, 4'b0000}) * PROD_W'(RECIP);
      neg_b  <= neg_a;
    end
  end

  assign quot   = prod_b[PROD_W-1:S];
  assign result = neg_b ? -OUT_W'(quot) : OUT_W'(quot);

endmodule

@@ rtl/sasf_merge.sv @@
// ----------------------------------------------------------------------------
// sasf_merge - pipeline control and result merge
// Tracks the stage valids, drives the lane loads and packs the lane
// results into the output register.
// ----------------------------------------------------------------------------
module sasf_merge
  import sasf_pkg::*;
#(
  parameter int AXIS_COUNT = AXIS_COUNT_DEF,
  parameter int TDATA_W    = ((AXIS_COUNT * OUT_W + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic signed [OUT_W-1:0] lane_res [AXIS_COUNT],
  output pipe_ctl_t               ctl,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [TDATA_W-1:0]      m_tdata
);

  logic v1, va, vb;
  logic en_1, en_a, en_b, en_c;
  logic [TDATA_W-1:0] packed_res;

  // a stage moves whenever it is empty or the one after it moves
  assign en_c = !m_tvalid || m_tready;
  assign en_b = !vb || en_c;
  assign en_a = !va || en_b;
  assign en_1 = !v1 || en_a;

  assign s_tready   = en_1;
  assign ctl.accept = s_tvalid && en_1;
  assign ctl.load_a = v1 && en_a;
  assign ctl.load_b = va && en_b;

  always_comb begin
    packed_res = '0;
    for (int a = 0; a < AXIS_COUNT; a++) begin
      packed_res[a*OUT_W +: OUT_W] = lane_res[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      va       <= 1'b0;
      vb       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en_1) v1 <= s_tvalid;
      if (en_a) va <= v1;
      if (en_b) vb <= va;
      if (en_c) m_tvalid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && vb) begin
      m_tdata <= packed_res;
    end
  end

  a_no_full_stall : assert property (@(posedge clk) disable iff (rst)
    !(v1 && va && vb && m_tvalid) |-> s_tready)
    else $error("input stalled with a bubble in the pipeline");

  a_b_to_out : assert property (@(posedge clk) disable iff (rst)
    (vb && en_c) |=> m_tvalid)
    else $error("result lost between product stage and output");

  a_a_hold : assert property (@(posedge clk) disable iff (rst)
    (va && !en_b) |=> va)
    else $error("magnitude stage dropped while stalled");

  a_no_dup : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !vb) |=> !m_tvalid)
    else $error("output beat repeated");

endmodule

@@ rtl/six_axis_smoothing_filter.sv @@
// ----------------------------------------------------------------------------
// six_axis_smoothing_filter - five-tap moving average with offset removal
// Per-axis smoothing of accel and gyro samples into fixed-point results.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one 16-bit signed sample per axis; each beat halves the
//   sample with the newest history entry (toward zero), shifts it into the
//   per-axis history and yields one m_tdata beat: the history mean minus the
//   axis offset, 21-bit signed with four fractional bits, truncated.
//   Offsets are written through cfg_we / cfg_index / cfg_data while idle;
//   an index past the last axis is ignored.
//   Throughput: one beat per cycle while m_tready stays high, set by a
//   four-register pipeline (history update, offset removal, reciprocal multiply, output register).
//   Each stage moves into any free slot, so the input keeps taking beats
//   while a result waits, until all four stages are full; then s_tready
//   drops and everything holds until m_tready returns.
//   Reset clears the history, the running sums and all valids, and loads
//   the default offsets (gyro x -59, gyro y and z 4, others 0).
// ----------------------------------------------------------------------------
module six_axis_smoothing_filter
  import sasf_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int AXIS_COUNT    = AXIS_COUNT_DEF,
  parameter int IDX_W         = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1,
  parameter int IN_TDATA_W    = AXIS_COUNT * SAMPLE_W,
  parameter int OUT_TDATA_W   = ((AXIS_COUNT * OUT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // accel_x_in, accel_y_in, accel_z_in, gyro_x_in, gyro_y_in, gyro_z_in
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // accel_x_out, accel_y_out, accel_z_out, gyro_x_out, gyro_y_out,
  // gyro_z_out, zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [OFFSET_W-1:0]    cfg_data
);

  pipe_ctl_t ctl;
  logic signed [OUT_W-1:0] lane_res [AXIS_COUNT];

  for (genvar a = 0; a < AXIS_COUNT; a++) begin : g_lane
    sasf_lane #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .IDX_W         (IDX_W),
      .LANE          (a)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .cfg_we    (cfg_we),
      .cfg_index (cfg_index),
      .cfg_data  (cfg_data),
      .sample    (s_tdata[a*SAMPLE_W +: SAMPLE_W]),
      .result    (lane_res[a])
    );
  end

  sasf_merge #(
    .AXIS_COUNT (AXIS_COUNT),
    .TDATA_W    (OUT_TDATA_W)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .lane_res (lane_res),
    .ctl      (ctl),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ tb/six_axis_smoothing_filter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// six_axis_smoothing_filter_tb - self-checking bench for the smoothing filter
// Streams six-axis sample sets through the filter under random idle cycles on
// both sides and one long output stall. A local model of the per-axis
// halving, five-deep history and offset-corrected mean predicts every result
// beat, which is compared axis by axis. Offsets change between phases.
// ----------------------------------------------------------------------------
module six_axis_smoothing_filter_tb;
  import sasf_pkg::*;

  localparam int AXES        = AXIS_COUNT_DEF;
  localparam int DEPTH       = HISTORY_DEPTH_DEF;
  localparam int IN_TDATA_W  = AXES * SAMPLE_W;
  localparam int OUT_TDATA_W = ((AXES * OUT_W + 7) / 8) * 8;
  localparam int IDLE_PCT    = 9;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_BEATS = 150;
  localparam int CYCLE_LIMIT = 50000;

  typedef enum logic [2:0] {
    REG_ACCEL_X, REG_ACCEL_Y, REG_ACCEL_Z,
    REG_GYRO_X, REG_GYRO_Y, REG_GYRO_Z,
    REG_UNUSED_6, REG_UNUSED_7
  } offset_reg_t;

  typedef logic [AXES-1:0][SAMPLE_W-1:0] sample_set_t;
  typedef logic [AXES-1:0][OUT_W-1:0]    filt_set_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // accel_x_in, accel_y_in, accel_z_in, gyro_x_in, gyro_y_in, gyro_z_in
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // accel_x_out, accel_y_out, accel_z_out, gyro_x_out, gyro_y_out,
  // gyro_z_out, zero fill
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [2:0]             cfg_index = '0;
  logic [OFFSET_W-1:0]    cfg_data = '0;

  // sequencer controls
  logic quiet = 1'b0;
  logic hold_go = 1'b0;
  int   hold_left = 0;

  sample_set_t sample_q[$];
  filt_set_t   filt_q[$];

  // model state
  int hist_q [AXES][DEPTH];
  int offs_q [AXES];

  int errors = 0;
  int beats_in = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int settings = 0;
  int cycle_count = 0;

  string axis_name [AXES] = '{"accel_x", "accel_y", "accel_z",
                              "gyro_x", "gyro_y", "gyro_z"};

  six_axis_smoothing_filter DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  // Halve each sample with the newest history entry, shift it in, then
  // take the offset-corrected mean scaled by 16, truncated toward zero.
  function automatic filt_set_t smooth_and_scale(input sample_set_t s);
    filt_set_t r;
    int        smp;
    int        sm;
    longint    sum;
    longint    scaled;
    for (int a = 0; a < AXES; a++) begin
      smp = $signed(s[a]);
      sm = (smp + hist_q[a][DEPTH-1]) / 2;
      for (int d = 0; d < DEPTH - 1; d++) hist_q[a][d] = hist_q[a][d+1];
      hist_q[a][DEPTH-1] = sm;
      sum = 0;
      for (int d = 0; d < DEPTH; d++) sum += longint'(hist_q[a][d]) - longint'(offs_q[a]);
      scaled = (sum * 16) / DEPTH;
      r[a] = scaled[OUT_W-1:0];
    end
    return r;
  endfunction

  function automatic sample_set_t all_axes(input logic [SAMPLE_W-1:0] v);
    sample_set_t s;
    for (int a = 0; a < AXES; a++) s[a] = v;
    return s;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return 16'($urandom);
    else if (pick < 80) return 16'h7FFF;
    else if (pick < 90) return 16'h8000;
    else return 16'($urandom_range(63) - 32);
  endfunction

  function automatic sample_set_t rand_sample_set();
    sample_set_t s;
    for (int a = 0; a < AXES; a++) s[a] = rand_value();
    return s;
  endfunction

  // driver: hold a beat until taken, otherwise offer the next one or idle
  always @(posedge clk) begin : drive_proc
    logic take;
    take = s_tvalid && s_tready;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (take) begin
        filt_q.push_back(smooth_and_scale(s_tdata));
        void'(sample_q.pop_front());
        beats_in++;
      end
      if (s_tvalid && !take) begin
        // hold
      end else if (sample_q.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= sample_q[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin : watch_proc
    filt_set_t          want;
    logic [OUT_W-1:0]   got;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (filt_q.size() == 0) begin
        report_mismatch("result beat with no prediction pending");
      end else begin
        want = filt_q.pop_front();
        for (int a = 0; a < AXES; a++) begin
          got = m_tdata[a*OUT_W +: OUT_W];
          if (got !== want[a])
            report_mismatch($sformatf("%s_out got %0d, predicted %0d", axis_name[a],
                                      $signed(got), $signed(want[a])));
        end
        if (m_tdata[OUT_TDATA_W-1:AXES*OUT_W] !== '0)
          report_mismatch("fill bits above the last axis are not zero");
      end
    end
    if (rst || hold_left != 0) m_tready <= 1'b0;
    else m_tready <= quiet || $urandom_range(99) >= IDLE_PCT;
  end

  // long output stall, counted here
  always @(posedge clk) begin
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d predictions pending", cycle_count,
               filt_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_offset(input offset_reg_t idx, input logic [OFFSET_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (int'(idx) < AXES) offs_q[idx] = $signed(val);
    reg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_beat(input sample_set_t s);
    sample_q.push_back(s);
  endtask

  // drain everything, then let the pipeline settle
  task automatic wait_idle(input int settle);
    do @(negedge clk); while (sample_q.size() != 0 || s_tvalid || filt_q.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  initial begin : sequence_proc
    logic [OFFSET_W-1:0] val;
    for (int a = 0; a < AXES; a++) begin
      offs_q[a] = OFFSET_RESET[a];
      for (int d = 0; d < DEPTH; d++) hist_q[a][d] = 0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    settings = 1;

    // directed: default offsets, extremes held long enough to fill history
    @(negedge clk);
    push_beat(all_axes(16'h0000));
    repeat (5) push_beat(all_axes(16'h7FFF));
    repeat (5) push_beat(all_axes(16'h8000));
    push_beat({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    push_beat(all_axes(16'h5555));
    push_beat(all_axes(16'hAAAA));
    push_beat(all_axes(16'hFFFF));
    wait_idle(4);

    // extreme offsets, plus writes past the last axis that must be ignored
    for (int a = 0; a < AXES; a++)
      write_offset(offset_reg_t'(a), (a < AXES / 2) ? 16'h8000 : 16'h7FFF);
    write_offset(REG_UNUSED_6, 16'($urandom));
    write_offset(REG_UNUSED_7, 16'($urandom));
    settings++;
    @(negedge clk);
    repeat (5) push_beat(all_axes(16'h7FFF));
    repeat (5) push_beat(all_axes(16'h8000));
    wait_idle(4);

    for (int p = 0; p < RAND_PHASES; p++) begin
      for (int a = 0; a < AXES; a++) begin
        case (p)
          1:       val = 16'h7FFF;
          2:       val = 16'h8000;
          3:       val = 16'h0000;
          default: val = ($urandom_range(99) < 20) ? rand_value() : 16'($urandom);
        endcase
        write_offset(offset_reg_t'(a), val);
      end
      settings++;
      if (p == 0) begin
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      if (p == 1) begin
        @(posedge clk);
        quiet <= 1'b1;
      end
      @(negedge clk);
      repeat (PHASE_BEATS) push_beat(rand_sample_set());
      wait_idle(4);
      if (p == 1) begin
        @(posedge clk);
        quiet <= 1'b0;
      end
    end

    wait_idle(8);
    $display("Covered %0d input beats and %0d result beats over %0d offset settings (%0d writes).",
             beats_in, results_seen, settings, reg_writes);
    $display("Included a %0d-cycle output stall with input backed up and a gap-free phase.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
